/* src/mhhpm_pkg.sv */
// package for the multi-head heater power manager
// holds widths, command codes, head modes, config layout and the watt table
// no dependencies
package mhhpm_pkg;

    localparam int HEAD_COUNT = 4;
    localparam int HEAD_W     = (HEAD_COUNT > 1) ? $clog2(HEAD_COUNT) : 1;

    localparam logic [1:0] CMD_COOK  = 2'd0;
    localparam logic [1:0] CMD_FAULT = 2'd1;
    localparam logic [1:0] CMD_TEMP  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_HOT   = 2'd2;
    localparam logic [1:0] MODE_FAULT = 2'd3;

    localparam logic [2:0] REG_DERATE_START = 3'd0;
    localparam logic [2:0] REG_LIMIT_TEMP   = 3'd1;
    localparam logic [2:0] REG_STOP_TEMP    = 3'd2;
    localparam logic [2:0] REG_RESUME_TEMP  = 3'd3;
    localparam logic [2:0] REG_SOFT_POWER   = 3'd4;
    localparam logic [2:0] REG_SOFT_TICKS   = 3'd5;
    localparam logic [2:0] REG_RUN_PERIOD   = 3'd6;
    localparam logic [2:0] REG_LEVEL_LIMIT  = 3'd7;

    localparam logic [15:0] FAULT_POWER = 16'd800;
    localparam logic [15:0] PULSE_POWER = 16'd100;
    localparam logic [5:0]  PULSE_WRAP  = 6'd60;

    // ceil(2^30 / 100), exact divide by 100 for values below 2^23
    localparam logic [23:0] DIV100_RECIP = 24'd10737419;

    typedef struct packed {
        logic [15:0] derate_start;
        logic [15:0] limit_temp;
        logic [15:0] stop_temp;
        logic [15:0] resume_temp;
        logic [15:0] soft_power;
        logic [7:0]  soft_ticks;
        logic [7:0]  run_period;
        logic [3:0]  level_limit;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic              update;
        logic              start;    // load a head and begin derate
        logic              div_step;
        logic              mul_step;
        logic              finish;   // apply stop, soft start, pulse, write back
        logic [HEAD_W-1:0] head;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
    } dp_stat_t;

    function automatic logic [15:0] watt_of(input logic [3:0] lvl);
        logic [15:0] w;
        begin
            case (lvl)
                4'd1:    w = 16'd200;
                4'd2:    w = 16'd300;
                4'd3:    w = 16'd400;
                4'd4:    w = 16'd500;
                4'd5:    w = 16'd1000;
                4'd6:    w = 16'd1100;
                4'd7:    w = 16'd1200;
                4'd8:    w = 16'd1300;
                4'd9:    w = 16'd1500;
                4'd10:   w = 16'd2000;
                default: w = 16'd0;
            endcase
            return w;
        end
    endfunction

endpackage

/* src/mhhpm_if.sv */
// valid/ready channel interfaces for requests and results
// no dependencies
interface mhhpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  head_sel;
    logic        cooking_on;
    logic [15:0] target_watts;
    logic [7:0]  heat_level;
    logic [15:0] fault_word;
    logic [15:0] switch_temp;
    logic [15:0] bottom_temp;
    modport source (output valid, command, head_sel, cooking_on, target_watts,
                    heat_level, fault_word, switch_temp, bottom_temp, input ready);
    modport sink   (input valid, command, head_sel, cooking_on, target_watts,
                    heat_level, fault_word, switch_temp, bottom_temp, output ready);
endinterface

interface mhhpm_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  head_number;
    logic        heat_active;
    logic [7:0]  level_echo;
    logic [15:0] applied_power;
    logic        last;
    modport source (output valid, head_number, heat_active, level_echo, applied_power, last,
                    input ready);
    modport sink   (input valid, head_number, heat_active, level_echo, applied_power, last,
                    output ready);
endinterface

/* src/mhhpm_cfg.sv */
// apb register file for the power manager settings
// depends on mhhpm_pkg
module mhhpm_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mhhpm_pkg::cfg_t   cfg
);
    mhhpm_pkg::cfg_t cfg_reg;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.derate_start <= 16'd80;
            cfg_reg.limit_temp   <= 16'd100;
            cfg_reg.stop_temp    <= 16'd250;
            cfg_reg.resume_temp  <= 16'd220;
            cfg_reg.soft_power   <= 16'd1000;
            cfg_reg.soft_ticks   <= 8'd5;
            cfg_reg.run_period   <= 8'd10;
            cfg_reg.level_limit  <= 4'd10;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                mhhpm_pkg::REG_DERATE_START: cfg_reg.derate_start <= pwdata[15:0];
                mhhpm_pkg::REG_LIMIT_TEMP:   cfg_reg.limit_temp   <= pwdata[15:0];
                mhhpm_pkg::REG_STOP_TEMP:    cfg_reg.stop_temp    <= pwdata[15:0];
                mhhpm_pkg::REG_RESUME_TEMP:  cfg_reg.resume_temp  <= pwdata[15:0];
                mhhpm_pkg::REG_SOFT_POWER:   cfg_reg.soft_power   <= pwdata[15:0];
                mhhpm_pkg::REG_SOFT_TICKS:   cfg_reg.soft_ticks   <= pwdata[7:0];
                mhhpm_pkg::REG_RUN_PERIOD:   cfg_reg.run_period   <= pwdata[7:0];
                mhhpm_pkg::REG_LEVEL_LIMIT:  cfg_reg.level_limit  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            mhhpm_pkg::REG_DERATE_START: prdata = {16'd0, cfg_reg.derate_start};
            mhhpm_pkg::REG_LIMIT_TEMP:   prdata = {16'd0, cfg_reg.limit_temp};
            mhhpm_pkg::REG_STOP_TEMP:    prdata = {16'd0, cfg_reg.stop_temp};
            mhhpm_pkg::REG_RESUME_TEMP:  prdata = {16'd0, cfg_reg.resume_temp};
            mhhpm_pkg::REG_SOFT_POWER:   prdata = {16'd0, cfg_reg.soft_power};
            mhhpm_pkg::REG_SOFT_TICKS:   prdata = {24'd0, cfg_reg.soft_ticks};
            mhhpm_pkg::REG_RUN_PERIOD:   prdata = {24'd0, cfg_reg.run_period};
            mhhpm_pkg::REG_LEVEL_LIMIT:  prdata = {28'd0, cfg_reg.level_limit};
            default: prdata = 32'd0;
        endcase
    end
endmodule

/* src/mhhpm_dp.sv */
// datapath: per-head state, derate divider and multiplier, power steps
// depends on mhhpm_pkg
module mhhpm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mhhpm_pkg::cfg_t     cfg,
    input  mhhpm_pkg::dp_cmd_t  cmd,
    input  logic [1:0]          command,
    input  logic                cooking_on,
    input  logic [15:0]         target_watts,
    input  logic [7:0]          heat_level,
    input  logic [15:0]         fault_word,
    input  logic [15:0]         switch_temp,
    input  logic [15:0]         bottom_temp,
    output mhhpm_pkg::dp_stat_t stat,
    output logic [15:0]         power,
    output logic [7:0]          level
);
    localparam int N = mhhpm_pkg::HEAD_COUNT;
    localparam int HEAD_W_L = mhhpm_pkg::HEAD_W;

    logic [1:0]  mode_reg   [N];
    logic [15:0] target_reg [N];
    logic [7:0]  lvl_reg    [N];
    logic [15:0] fault_reg  [N];
    logic [15:0] igbt_reg   [N];
    logic [15:0] bot_reg    [N];
    logic [7:0]  soft_reg   [N];
    logic [15:0] saved_reg  [N];
    logic [5:0]  phase_reg  [N];

    // working registers for the head in evaluation
    logic [15:0] p_reg;
    logic [15:0] rem_reg;     // restoring division remainder
    logic [15:0] span_reg;
    logic [6:0]  quo_reg;     // quotient bits shift in; only the low 7 quotient bits are kept
    logic [22:0] num_reg;
    logic [4:0]  dcnt_reg;
    logic [22:0] prod_reg;    // p * (100 - drop), max 65535*100
    logic [6:0]  mul_reg;
    logic [2:0]  mcnt_reg;
    logic [1:0]  dphase_reg;  // 0 pass through, 1 zero, 2 derate
    logic [15:0] der_reg;     // prod / 100
    logic [15:0] power_reg;

    logic [HEAD_W_L-1:0] h;
    assign h = cmd.head;

    logic [15:0] base_p;
    logic [15:0] tbl_p;
    always_comb
    begin
        tbl_p = 16'd0;
        if (lvl_reg[h] <= {4'd0, cfg.level_limit} && lvl_reg[h] <= 8'd10)
            tbl_p = mhhpm_pkg::watt_of(lvl_reg[h][3:0]);
        base_p = target_reg[h];
        if (target_reg[h] == 16'd0 && lvl_reg[h] != 8'd0)
            base_p = tbl_p;
    end

    // dividend (t - start) * 100 fits in 23 bits
    logic [15:0] tdiff;
    logic [22:0] tdiff100;
    assign tdiff    = igbt_reg[h] - cfg.derate_start;
    assign tdiff100 = 23'({tdiff, 6'd0}) + 23'({tdiff, 5'd0}) + 23'({tdiff, 2'd0});

    // quotient is below 100 since t < limit, so 7 quotient bits suffice
    // but the full dividend needs a long division: 23 steps
    logic [16:0] trial;
    assign trial = {rem_reg, num_reg[22]} - {1'b0, span_reg};

    // divide by 100 through a reciprocal multiply
    logic [46:0] scaled;
    assign scaled = 47'(prod_reg) * 47'(mhhpm_pkg::DIV100_RECIP);

    // finishing path
    logic [15:0] derated;
    logic [15:0] after_stop;
    logic        goes_hot;
    logic [15:0] soft_p;
    logic [15:0] saved_n;
    logic [7:0]  soft_n;
    logic [15:0] out_p;
    logic [5:0]  phase_n;
    logic [5:0]  phase_inc;
    logic [5:0]  on_cnt;
    logic [7:0]  cnt_tmp;

    always_comb
    begin
        derated = p_reg;
        if (dphase_reg == 2'd1)
            derated = 16'd0;
        else if (dphase_reg == 2'd2)
            derated = der_reg;
        goes_hot   = 1'b0;
        after_stop = derated;
        if (derated != 16'd0 && bot_reg[h] >= cfg.stop_temp)
        begin
            goes_hot   = 1'b1;
            after_stop = 16'd0;
        end
        saved_n = saved_reg[h];
        soft_n  = soft_reg[h];
        cnt_tmp = soft_reg[h];
        soft_p  = after_stop;
        if (after_stop <= cfg.soft_power)
        begin
            saved_n = 16'd0;
            soft_n  = 8'd0;
            soft_p  = after_stop;
        end
        else
        begin
            if (saved_reg[h] != after_stop)
            begin
                saved_n = after_stop;
                cnt_tmp = cfg.soft_ticks;
            end
            if (cnt_tmp != 8'd0)
            begin
                soft_n = cnt_tmp - 8'd1;
                soft_p = cfg.soft_power;
            end
            else
            begin
                soft_n = cnt_tmp;
                soft_p = saved_n;
            end
        end
        phase_inc = (phase_reg[h] == mhhpm_pkg::PULSE_WRAP - 6'd1) ? 6'd0
                                                                    : phase_reg[h] + 6'd1;
        phase_n = 6'd0;
        out_p   = soft_p;
        on_cnt  = 6'd0;
        if (soft_p < mhhpm_pkg::PULSE_POWER)
        begin
            phase_n = phase_inc;
            if (soft_p >= 16'd50)
                on_cnt = 6'd30;
            else if (soft_p >= 16'd25)
                on_cnt = 6'd15;
            out_p = (phase_inc < on_cnt) ? mhhpm_pkg::PULSE_POWER : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                mode_reg[i]   <= mhhpm_pkg::MODE_OFF;
                target_reg[i] <= 16'd0;
                lvl_reg[i]    <= 8'd0;
                fault_reg[i]  <= 16'd0;
                igbt_reg[i]   <= 16'd25;
                bot_reg[i]    <= 16'd25;
                soft_reg[i]   <= 8'd0;
                saved_reg[i]  <= 16'd0;
                phase_reg[i]  <= 6'd0;
            end
            p_reg      <= 16'd0;
            rem_reg    <= 16'd0;
            span_reg   <= 16'd0;
            quo_reg    <= 7'd0;
            num_reg    <= 23'd0;
            prod_reg   <= 23'd0;
            mul_reg    <= 7'd0;
            der_reg    <= 16'd0;
            power_reg  <= 16'd0;
            dcnt_reg   <= 5'd0;
            mcnt_reg   <= 3'd0;
            dphase_reg <= 2'd0;
        end
        else
        begin
            if (cmd.update)
            begin
                case (command)
                    mhhpm_pkg::CMD_COOK:
                    begin
                        target_reg[h] <= target_watts;
                        lvl_reg[h]    <= heat_level;
                        if (!cooking_on)
                            mode_reg[h] <= mhhpm_pkg::MODE_OFF;
                        else if (mode_reg[h] == mhhpm_pkg::MODE_OFF)
                        begin
                            mode_reg[h]  <= mhhpm_pkg::MODE_RUN;
                            soft_reg[h]  <= 8'd0;
                            saved_reg[h] <= 16'd0;
                        end
                    end
                    mhhpm_pkg::CMD_FAULT:
                    begin
                        fault_reg[h] <= fault_word;
                        if (fault_word != 16'd0 && mode_reg[h] == mhhpm_pkg::MODE_RUN)
                            mode_reg[h] <= mhhpm_pkg::MODE_FAULT;
                        if (fault_word == 16'd0 && mode_reg[h] == mhhpm_pkg::MODE_FAULT)
                            mode_reg[h] <= mhhpm_pkg::MODE_RUN;
                    end
                    mhhpm_pkg::CMD_TEMP:
                    begin
                        igbt_reg[h] <= switch_temp;
                        bot_reg[h]  <= bottom_temp;
                    end
                    default: ;
                endcase
            end
            if (cmd.start)
            begin
                p_reg    <= base_p;
                span_reg <= cfg.limit_temp - cfg.derate_start;
                num_reg  <= tdiff100;
                rem_reg  <= 16'd0;
                quo_reg  <= 7'd0;
                dcnt_reg <= 5'd0;
                mcnt_reg <= 3'd0;
                if (base_p == 16'd0 || igbt_reg[h] < cfg.derate_start)
                    dphase_reg <= 2'd0;
                else if (igbt_reg[h] >= cfg.limit_temp)
                    dphase_reg <= 2'd1;
                else
                    dphase_reg <= 2'd2;
            end
            if (cmd.div_step)
            begin
                num_reg  <= {num_reg[21:0], 1'b0};
                dcnt_reg <= dcnt_reg + 5'd1;
                if (!trial[16])
                begin
                    rem_reg <= trial[15:0];
                    quo_reg <= {quo_reg[5:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[14:0], num_reg[22]};
                    quo_reg <= {quo_reg[5:0], 1'b0};
                end
                if (dcnt_reg == 5'd22)
                begin
                    prod_reg <= 23'd0;
                    mul_reg  <= 7'd0;
                end
            end
            // three steps: load factor, multiply, scale down by 100
            if (cmd.mul_step)
            begin
                if (mcnt_reg == 3'd0)
                begin
                    mul_reg  <= 7'd100 - quo_reg;
                    prod_reg <= 23'd0;
                end
                else if (mcnt_reg == 3'd1)
                    prod_reg <= 23'(p_reg) * 23'(mul_reg);
                else
                    der_reg <= scaled[45:30];
                mcnt_reg <= mcnt_reg + 3'd1;
            end
            if (cmd.finish)
            begin
                case (mode_reg[h])
                    mhhpm_pkg::MODE_FAULT:
                        power_reg <= fault_reg[h][14] ? mhhpm_pkg::FAULT_POWER : 16'd0;
                    mhhpm_pkg::MODE_HOT:
                    begin
                        power_reg <= 16'd0;
                        if (bot_reg[h] <= cfg.resume_temp)
                            mode_reg[h] <= mhhpm_pkg::MODE_RUN;
                    end
                    mhhpm_pkg::MODE_RUN:
                    begin
                        if (goes_hot)
                            mode_reg[h] <= mhhpm_pkg::MODE_HOT;
                        saved_reg[h] <= saved_n;
                        soft_reg[h]  <= soft_n;
                        phase_reg[h] <= phase_n;
                        power_reg    <= out_p;
                    end
                    default: power_reg <= 16'd0;
                endcase
            end
        end
    end

    assign stat.div_done = (dcnt_reg == 5'd23);
    assign stat.mul_done = (mcnt_reg == 3'd2);
    assign power = power_reg;
    assign level = lvl_reg[h];
endmodule

/* src/mhhpm_ctrl.sv */
// controller: request intake, tick counting, head walk and result register
// depends on mhhpm_pkg
module mhhpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  mhhpm_pkg::cfg_t     cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [7:0]          head_sel,
    output mhhpm_pkg::dp_cmd_t  cmd,
    input  mhhpm_pkg::dp_stat_t stat,
    input  logic [15:0]         power,
    input  logic [7:0]          level,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          head_number,
    output logic                heat_active,
    output logic [7:0]          level_echo,
    output logic [15:0]         applied_power,
    output logic                last
);
    localparam int HW = mhhpm_pkg::HEAD_W;
    localparam logic [HW-1:0] LAST_HEAD = HW'(mhhpm_pkg::HEAD_COUNT - 1);

    typedef enum logic [2:0] {S_IDLE, S_START, S_DIV, S_MUL, S_FIN, S_OUT} state_t;

    state_t       state_reg;
    logic [HW-1:0] head_reg;
    logic [7:0]   tick_reg;
    logic         valid_reg;
    logic [15:0]  pwr_reg;
    logic [7:0]   lvl_reg;
    logic [2:0]   num_reg;
    logic         last_reg;
    logic [7:0]   tick_next;

    logic take;
    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;
    assign tick_next = tick_reg + 8'd1;

    always_comb
    begin
        cmd          = '0;
        cmd.head     = (state_reg == S_IDLE) ? head_sel[HW-1:0] : head_reg;
        cmd.update   = take && command != mhhpm_pkg::CMD_TICK
                       && head_sel < 8'(mhhpm_pkg::HEAD_COUNT);
        cmd.start    = (state_reg == S_START);
        cmd.div_step = (state_reg == S_DIV) && !stat.div_done;
        cmd.mul_step = (state_reg == S_MUL);
        cmd.finish   = (state_reg == S_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tick_reg  <= 8'd0;
            valid_reg <= 1'b0;
            pwr_reg   <= 16'd0;
            lvl_reg   <= 8'd0;
            num_reg   <= 3'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (take && command == mhhpm_pkg::CMD_TICK)
                    begin
                        if (tick_next < cfg.run_period)
                            tick_reg <= tick_next;
                        else
                        begin
                            tick_reg  <= 8'd0;
                            head_reg  <= '0;
                            state_reg <= S_START;
                        end
                    end
                S_START: state_reg <= S_DIV;
                S_DIV:   if (stat.div_done) state_reg <= S_MUL;
                S_MUL:   if (stat.mul_done) state_reg <= S_FIN;
                S_FIN:   state_reg <= S_OUT;
                S_OUT:
                    if (!valid_reg)
                    begin
                        valid_reg <= 1'b1;
                        pwr_reg   <= power;
                        lvl_reg   <= level;
                        num_reg   <= 3'(head_reg);
                        last_reg  <= (head_reg == LAST_HEAD);
                        if (head_reg == LAST_HEAD)
                            state_reg <= S_IDLE;
                        else
                        begin
                            head_reg  <= head_reg + HW'(1);
                            state_reg <= S_START;
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
            if (valid_reg && out_ready)
                valid_reg <= 1'b0;
        end
    end

    assign out_valid     = valid_reg;
    assign head_number   = num_reg;
    assign heat_active   = (pwr_reg != 16'd0);
    assign level_echo    = lvl_reg;
    assign applied_power = pwr_reg;
    assign last          = last_reg;
endmodule

/* src/multi_head_heater_power_manager.sv */
// top level of the multi-head heater power manager
// depends on mhhpm_pkg, mhhpm_if, mhhpm_cfg, mhhpm_ctrl, mhhpm_dp
//
// usage:
//   req channel takes one request per cycle while idle: cooking, fault and
//   temperature updates and 10 ms ticks. updates and ticks that do not end a
//   run period give no result.
//   the tick that completes run_period_ticks starts a pass over all heads;
//   each head goes through load, the 23-step restoring divider for the igbt
//   derate, multiply and scale, finish and result load, and a pass covers
//   all four heads in turn. req.ready is low for the whole pass.
//   res channel carries one result per head, head order, last on the final
//   head. one output register holds it; a stalled receiver holds the walk
//   before the next head's result is loaded.
//   apb port writes the eight settings at byte address 4*i; write only
//   while idle. pready is always high.
//   reset: all heads off, readings 25, settings to defaults, no results.
module multi_head_heater_power_manager (
    input  logic        clk,
    input  logic        rst_n,
    mhhpm_req_if.sink   req,
    mhhpm_res_if.source res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    mhhpm_pkg::cfg_t     cfg;
    mhhpm_pkg::dp_cmd_t  cmd;
    mhhpm_pkg::dp_stat_t stat;
    logic [15:0]         power;
    logic [7:0]          level;

    mhhpm_cfg u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
    );

    mhhpm_ctrl u_ctrl (
        .clk, .rst_n, .cfg,
        .in_valid(req.valid), .in_ready(req.ready),
        .command(req.command), .head_sel(req.head_sel),
        .cmd, .stat, .power, .level,
        .out_valid(res.valid), .out_ready(res.ready),
        .head_number(res.head_number), .heat_active(res.heat_active),
        .level_echo(res.level_echo), .applied_power(res.applied_power),
        .last(res.last)
    );

    mhhpm_dp u_dp (
        .clk, .rst_n, .cfg, .cmd,
        .command(req.command), .cooking_on(req.cooking_on),
        .target_watts(req.target_watts), .heat_level(req.heat_level),
        .fault_word(req.fault_word), .switch_temp(req.switch_temp),
        .bottom_temp(req.bottom_temp),
        .stat, .power, .level
    );
endmodule
